### hw/rtl/caq_pkg.sv
// Package for the coalescing activation queue: sizes, request and status codes,
// and the command struct that joins the controller to the datapath.
// No dependencies.
package caq_pkg;

  localparam int MAX_CLIENTS = 16;
  localparam int SLOT_W      = $clog2(MAX_CLIENTS);
  localparam int COUNT_W     = $clog2(MAX_CLIENTS + 1);
  localparam int HANDLE_W    = 32;
  localparam int REQ_W       = 3;
  localparam int STATUS_W    = 3;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_ADD       = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ACTIVATE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP       = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TERMINATE = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_GRANT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TERM  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;

  typedef struct packed {
    logic capture;
    logic execute;
  } caq_cmd_t;

endpackage

### hw/rtl/caq_ctrl.sv
// Controller state machine of the coalescing activation queue.
// Depends on caq_pkg for the command struct.
module caq_ctrl
  import caq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output logic     done,
  output caq_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end
        end
        S_EXEC: begin
          state <= S_RESP;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        S_RESP: begin
          done <= 1'b0;
          if (start) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end else begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

  assign cmd.capture = start && !busy;
  assign cmd.execute = (state == S_EXEC);

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
      (start && !busy) |=> (busy && cmd.execute))
    else $error("accepted request not executed in the next cycle");
`endif

endmodule

### hw/rtl/caq_datapath.sv
// Datapath of the coalescing activation queue: slot tables, order and free
// queues, handle memory and result registers. Depends on caq_pkg.
module caq_datapath
  import caq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  caq_cmd_t            cmd,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [SLOT_W-1:0]   client_id,
  input  logic [HANDLE_W-1:0] client_handle,
  input  logic                deep_request,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot_out,
  output logic [HANDLE_W-1:0] handle_out,
  output logic                deep_out,
  output logic [COUNT_W-1:0]  client_count
);

  // Captured request.
  logic [REQ_W-1:0]    req_r;
  logic [SLOT_W-1:0]   id_r;
  logic [HANDLE_W-1:0] handle_r;
  logic                deep_r;

  // Slot state.
  logic [MAX_CLIENTS-1:0] in_use, in_use_next;
  logic [MAX_CLIENTS-1:0] pending, pending_next;
  logic [MAX_CLIENTS-1:0] deep_flags, deep_flags_next;
  logic [SLOT_W-1:0]      oq [MAX_CLIENTS];
  logic [SLOT_W-1:0]      oq_next [MAX_CLIENTS];
  logic [COUNT_W-1:0]     oq_count, oq_count_next;
  logic [SLOT_W-1:0]      fq [MAX_CLIENTS];
  logic [SLOT_W-1:0]      fq_next [MAX_CLIENTS];
  logic [COUNT_W-1:0]     fq_count, fq_count_next;
  logic [COUNT_W-1:0]     high_water, high_water_next;
  logic                   stop_flag, stop_flag_next;

  // Handle memory.
  logic [HANDLE_W-1:0] handle_mem [MAX_CLIENTS];
  logic [HANDLE_W-1:0] rd_data;
  logic                mem_we;
  logic [SLOT_W-1:0]   alloc;

  // Result.
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [SLOT_W-1:0]   res_slot, res_slot_next;
  logic                res_deep, res_deep_next;
  logic                res_grant, res_grant_next;
  logic [COUNT_W-1:0]  res_count;

  // Queue compaction: entries above the removed one move down by one.
  logic [MAX_CLIENTS-1:0] match;
  logic [MAX_CLIENTS-1:0] shift_mask;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r    <= req_type;
      id_r     <= client_id;
      handle_r <= client_handle;
      deep_r   <= deep_request;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_CLIENTS; i++) begin
      match[i] = (COUNT_W'(i) < oq_count) && (oq[i] == id_r);
    end
    for (int i = 0; i < MAX_CLIENTS; i++) begin
      shift_mask[i] = |(match & MAX_CLIENTS'((2 ** (i + 1)) - 1));
    end
  end

  always_comb begin
    logic valid;
    logic add_ok;
    valid           = in_use[id_r];
    add_ok          = 1'b0;
    alloc           = fq[0];
    mem_we          = 1'b0;
    in_use_next     = in_use;
    pending_next    = pending;
    deep_flags_next = deep_flags;
    oq_next         = oq;
    oq_count_next   = oq_count;
    fq_next         = fq;
    fq_count_next   = fq_count;
    high_water_next = high_water;
    stop_flag_next  = stop_flag;
    res_status_next = ST_DONE;
    res_slot_next   = '0;
    res_deep_next   = 1'b0;
    res_grant_next  = 1'b0;

    case (req_r)
      REQ_ADD: begin
        if (fq_count != '0) begin
          alloc = fq[0];
          for (int i = 0; i < MAX_CLIENTS - 1; i++) begin
            fq_next[i] = fq[i + 1];
          end
          fq_count_next = fq_count - 1'b1;
          add_ok        = 1'b1;
        end else if (high_water < COUNT_W'(MAX_CLIENTS)) begin
          alloc           = high_water[SLOT_W-1:0];
          high_water_next = high_water + 1'b1;
          add_ok          = 1'b1;
        end else begin
          res_status_next = ST_FULL;
        end
        if (add_ok) begin
          mem_we                 = 1'b1;
          deep_flags_next[alloc] = 1'b0;
          in_use_next[alloc]     = 1'b1;
          res_slot_next          = alloc;
        end
      end
      REQ_ACTIVATE: begin
        if (valid) begin
          if (!pending[id_r]) begin
            pending_next[id_r] = 1'b1;
            if (oq_count < COUNT_W'(MAX_CLIENTS)) begin
              oq_next[oq_count[SLOT_W-1:0]] = id_r;
              oq_count_next                 = oq_count + 1'b1;
            end
            deep_flags_next[id_r] = deep_r;
          end else if (deep_r) begin
            deep_flags_next[id_r] = 1'b1;
          end
        end
      end
      REQ_REMOVE: begin
        if (valid) begin
          if (pending[id_r]) begin
            pending_next[id_r] = 1'b0;
            for (int i = 0; i < MAX_CLIENTS - 1; i++) begin
              if (shift_mask[i]) begin
                oq_next[i] = oq[i + 1];
              end
            end
            if (match != '0) begin
              oq_count_next = oq_count - 1'b1;
            end
          end
          deep_flags_next[id_r] = 1'b0;
          in_use_next[id_r]     = 1'b0;
          if (fq_count < COUNT_W'(MAX_CLIENTS)) begin
            fq_next[fq_count[SLOT_W-1:0]] = id_r;
            fq_count_next                 = fq_count + 1'b1;
          end
        end
      end
      REQ_POP: begin
        if (stop_flag) begin
          stop_flag_next  = 1'b0;
          res_status_next = ST_TERM;
        end else if (oq_count != '0) begin
          for (int i = 0; i < MAX_CLIENTS - 1; i++) begin
            oq_next[i] = oq[i + 1];
          end
          oq_count_next         = oq_count - 1'b1;
          pending_next[oq[0]]   = 1'b0;
          deep_flags_next[oq[0]] = 1'b0;
          res_status_next       = ST_GRANT;
          res_slot_next         = oq[0];
          res_deep_next         = deep_flags[oq[0]];
          res_grant_next        = 1'b1;
        end else begin
          res_status_next = ST_EMPTY;
        end
      end
      REQ_TERMINATE: begin
        stop_flag_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use     <= '0;
      pending    <= '0;
      deep_flags <= '0;
      oq_count   <= '0;
      fq_count   <= '0;
      high_water <= '0;
      stop_flag  <= 1'b0;
    end else if (cmd.execute) begin
      in_use     <= in_use_next;
      pending    <= pending_next;
      deep_flags <= deep_flags_next;
      oq_count   <= oq_count_next;
      fq_count   <= fq_count_next;
      high_water <= high_water_next;
      stop_flag  <= stop_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      oq         <= oq_next;
      fq         <= fq_next;
      res_status <= res_status_next;
      res_slot   <= res_slot_next;
      res_deep   <= res_deep_next;
      res_grant  <= res_grant_next;
      res_count  <= high_water_next - fq_count_next;
    end
  end

  // The head of the order queue is read in the execute cycle; only a pop uses it.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      rd_data <= handle_mem[oq[0]];
      if (mem_we) begin
        handle_mem[alloc] <= handle_r;
      end
    end
  end

  assign status       = res_status;
  assign slot_out     = res_slot;
  assign handle_out   = res_grant ? rd_data : '0;
  assign deep_out     = res_deep;
  assign client_count = res_count;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
      oq_count <= COUNT_W'(MAX_CLIENTS))
    else $error("order queue count beyond table size");
  a_pending_count: assert property (@(posedge clk) disable iff (rst)
      COUNT_W'($countones(pending)) == oq_count)
    else $error("pending map disagrees with order queue length");
  a_in_use_count: assert property (@(posedge clk) disable iff (rst)
      COUNT_W'($countones(in_use)) == (high_water - fq_count))
    else $error("slots in use disagree with allocation counters");
`endif

endmodule

### hw/rtl/coalescing_activation_queue_unit.sv
// Top level of the coalescing activation queue: controller plus datapath.
// Depends on caq_pkg, caq_ctrl and caq_datapath.
//
// A request is transferred at a rising clock edge with start high and busy
// low. Every request produces exactly one result, shown on status, slot_out,
// handle_out, deep_out and client_count for one cycle while done is high;
// the receiver cannot stall, so it must take the result in that cycle. The
// request is applied to the slot tables and queues in the execute state; in
// the result state the registered result is presented together with the
// handle read from the slot memory. busy is low during the result cycle, so a
// new request can be transferred there while the result of the last one is
// shown. Every request type, including removal from the middle of the
// activation queue, takes the same time: the queue compacts in a single
// update. Add returns the oldest freed slot, else the next never-used one,
// else status "no free slot". A pop returns termination first if it was
// requested, else the oldest pending client and its deep flag, else status
// "nothing pending". Handles of slots that were never added are not defined.
module coalescing_activation_queue_unit
  import caq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [SLOT_W-1:0]   client_id,
  input  logic [HANDLE_W-1:0] client_handle,
  input  logic                deep_request,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot_out,
  output logic [HANDLE_W-1:0] handle_out,
  output logic                deep_out,
  output logic [COUNT_W-1:0]  client_count
);

  caq_cmd_t cmd;

  // The controller sequences each transfer through execute and result cycles.
  caq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // The datapath holds all client state and the result registers.
  caq_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req_type      (req_type),
    .client_id     (client_id),
    .client_handle (client_handle),
    .deep_request  (deep_request),
    .status        (status),
    .slot_out      (slot_out),
    .handle_out    (handle_out),
    .deep_out      (deep_out),
    .client_count  (client_count)
  );

endmodule
